>>> rtl/core/grain_sample_player_unit_macros.svh
// Assertion macros shared by the grain sample player checker.
// Needs signals named clk and rst in the scope where a macro is used.
`ifndef GRAIN_SAMPLE_PLAYER_UNIT_MACROS_SVH
`define GRAIN_SAMPLE_PLAYER_UNIT_MACROS_SVH

// same-cycle implication, masked while in reset
`define GSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked while in reset
`define GSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define GSP_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/gsp_pkg.sv
// Shared types and constants for the grain sample player.
// No dependencies.
package gsp_pkg;

  localparam int PHASE_W  = 32;
  localparam int LEN_W    = 17;
  localparam int IDX_W    = 16;
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 24;
  localparam int SF_W     = 16;
  localparam int FRAC_MAX = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = 2;
  localparam int RQ_CNT_W = 3;

  // item kinds on s_tuser
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_REVERSE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAIN_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_FRACTION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT   = 3'd4;

  localparam logic [COUNT_W-1:0] PITCH_RESET = 24'd256;

  // tick issued to the datapath, one per output beat
  typedef struct packed {
    logic                valid;
    logic                zero;   // grain already done: output 0
    logic                fin;    // done flag after this tick
    logic [FRAC_MAX-1:0] frac;
  } tick_info_t;

endpackage

>>> rtl/core/gsp_sram.sv
// Sample memory: one write port, one registered read port.
// Depends on nothing.
module gsp_sram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-before-write on a same-address collision
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/gsp_seq.sv
// Front end: config registers, grain state, input decode and memory addressing.
// Depends on gsp_pkg.
module gsp_seq
  import gsp_pkg::*;
#(
  parameter int FRAC_BITS    = 8,
  parameter int SAMPLE_DEPTH = 65536,
  parameter int AW           = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,
  input  logic [1:0]            s_tuser,
  input  logic                  out_pop,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [SAMPLE_W-1:0]   wr_data,
  output logic [AW-1:0]         rd_addr,
  output tick_info_t            issue
);

  localparam int IX_W = PHASE_W - FRAC_BITS;
  localparam logic [24:0] DEPTH_V = 25'(SAMPLE_DEPTH);

  // config registers
  logic [COUNT_W-1:0] pitch_step;
  logic               play_reverse;
  logic [COUNT_W-1:0] grain_length;
  logic [SF_W-1:0]    start_fraction;
  logic [LEN_W-1:0]   sample_count;

  // grain state
  logic [PHASE_W-1:0] phase, phase_next;
  logic [COUNT_W-1:0] samples_left, left_next;
  logic               finished, fin_next;

  logic [RQ_CNT_W-1:0] credits;
  tick_info_t          issue_q;
  logic [AW-1:0]       nidx_q;

  logic               in_acc, tick_acc;
  logic [IDX_W-1:0]   load_address;
  logic [LEN_W-1:0]   len;
  logic [IDX_W-1:0]   last, idx_c, nidx;
  logic [IX_W-1:0]    idx_raw;
  logic [COUNT_W-1:0] left_dec;
  logic [PHASE_W-1:0] phase_add, phase_sub, phase_start;
  logic [2*IDX_W-1:0] sprod;
  logic               fwd_end, rev_end, start_done;

  assign in_acc       = s_tvalid & s_tready;
  assign tick_acc     = in_acc && (s_tuser == OP_TICK);
  assign load_address = s_tdata[15:0];
  assign s_tready     = !issue_q.valid && (credits != RQ_CNT_W'(RQ_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_step     <= PITCH_RESET;
      play_reverse   <= 1'b0;
      grain_length   <= '0;
      start_fraction <= '0;
      sample_count   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PITCH_STEP:     pitch_step     <= cfg_data;
        REG_PLAY_REVERSE:   play_reverse   <= cfg_data[0];
        REG_GRAIN_LENGTH:   grain_length   <= cfg_data;
        REG_START_FRACTION: start_fraction <= cfg_data[SF_W-1:0];
        REG_SAMPLE_COUNT:   sample_count   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective length, last entry, read indexes
  always_comb begin
    len = (25'(sample_count) > DEPTH_V) ? LEN_W'(DEPTH_V) : sample_count;
    last = (len != '0) ? IDX_W'(len - LEN_W'(1)) : '0;
    idx_raw = phase[PHASE_W-1:FRAC_BITS];
    idx_c = (idx_raw > IX_W'(last)) ? last : IDX_W'(idx_raw);
    nidx = ((LEN_W'(idx_c) + LEN_W'(1)) < len) ? idx_c + IDX_W'(1) : idx_c;
  end

  // end test carries one extra bit so a top index plus one does not wrap
  always_comb begin
    left_dec    = samples_left - COUNT_W'(1);
    phase_add   = phase + PHASE_W'(pitch_step);
    phase_sub   = phase - PHASE_W'(pitch_step);
    rev_end     = phase < PHASE_W'(pitch_step);
    fwd_end     = ({1'b0, phase_add[PHASE_W-1:FRAC_BITS]} + (IX_W+1)'(1))
                  >= (IX_W+1)'(len);
    sprod       = start_fraction * last;
    phase_start = PHASE_W'(sprod[2*IDX_W-1:IDX_W]) << FRAC_BITS;
    start_done  = (len <= LEN_W'(1)) || (grain_length == '0);
  end

  always_comb begin
    phase_next = phase;
    left_next  = samples_left;
    fin_next   = finished;
    if (in_acc) begin
      unique case (s_tuser)
        OP_START: begin
          left_next  = grain_length;
          fin_next   = start_done;
          phase_next = start_done ? '0 : phase_start;
        end
        OP_TICK: begin
          if (!finished) begin
            left_next = left_dec;
            if (left_dec == '0) begin
              fin_next = 1'b1;
            end else if (play_reverse) begin
              if (rev_end) begin
                fin_next = 1'b1;
              end else begin
                phase_next = phase_sub;
              end
            end else begin
              phase_next = phase_add;
              fin_next   = fwd_end;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= '0;
      samples_left <= '0;
      finished     <= 1'b1;
    end else begin
      phase        <= phase_next;
      samples_left <= left_next;
      finished     <= fin_next;
    end
  end

  // a tick then holds the read port, via nidx_q, to fetch the next entry
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_q.valid <= 1'b0;
    end else begin
      issue_q.valid <= tick_acc;
    end
    issue_q.zero <= finished;
    issue_q.fin  <= fin_next;
    issue_q.frac <= FRAC_MAX'(phase[FRAC_BITS-1:0]);
    nidx_q       <= AW'(nidx);
  end

  // ticks in flight or queued; bounds the result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits + RQ_CNT_W'(tick_acc) - RQ_CNT_W'(out_pop);
    end
  end

  assign wr_en   = in_acc && (s_tuser == OP_LOAD) && (25'(load_address) < DEPTH_V);
  assign wr_addr = AW'(load_address);
  assign wr_data = s_tdata[31:16];
  assign rd_addr = issue_q.valid ? nidx_q : AW'(idx_c);
  assign issue   = issue_q;

endmodule

>>> rtl/core/gsp_interp.sv
// Back end: interpolation pipeline and result queue feeding the output stream.
// Depends on gsp_pkg.
module gsp_interp
  import gsp_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  tick_info_t          issue,
  input  logic [SAMPLE_W-1:0] rdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata,
  output logic                m_tuser
);

  localparam int PROD_W = SAMPLE_W + FRAC_BITS + 2;

  tick_info_t                 s2_info, s3_info;
  logic [SAMPLE_W-1:0]        a_q, s3_a;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [FRAC_BITS:0]  frac_s;
  logic signed [PROD_W-1:0]   prod, s3_prod, prod_sh;
  logic [SAMPLE_W-1:0]        audio;

  logic [SAMPLE_W-1:0] rq_audio [RQ_DEPTH];
  logic                rq_fin   [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wptr, rptr;
  logic [RQ_CNT_W-1:0] count;
  logic                push, pop;

  // stage 2: first entry latched while the next entry is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_info.valid <= 1'b0;
    end else begin
      s2_info.valid <= issue.valid;
    end
    s2_info.zero <= issue.zero;
    s2_info.fin  <= issue.fin;
    s2_info.frac <= issue.frac;
    a_q          <= rdata;
  end

  always_comb begin
    diff   = $signed({rdata[SAMPLE_W-1], rdata}) - $signed({a_q[SAMPLE_W-1], a_q});
    frac_s = $signed({1'b0, s2_info.frac[FRAC_BITS-1:0]});
    prod   = diff * frac_s;
  end

  // stage 3: product registered
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_info.valid <= 1'b0;
    end else begin
      s3_info.valid <= s2_info.valid;
    end
    s3_info.zero <= s2_info.zero;
    s3_info.fin  <= s2_info.fin;
    s3_info.frac <= s2_info.frac;
    s3_prod      <= prod;
    s3_a         <= a_q;
  end

  // arithmetic shift floors toward minus infinity
  always_comb begin
    prod_sh = s3_prod >>> FRAC_BITS;
    audio   = s3_info.zero ? '0 : s3_a + prod_sh[SAMPLE_W-1:0];
  end

  assign push = s3_info.valid;
  assign pop  = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      rq_audio[wptr] <= audio;
      rq_fin[wptr]   <= s3_info.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + RQ_PTR_W'(push);
      rptr  <= rptr + RQ_PTR_W'(pop);
      count <= count + RQ_CNT_W'(push) - RQ_CNT_W'(pop);
    end
  end

  assign m_tvalid = (count != '0);
  assign m_tdata  = rq_audio[rptr];
  assign m_tuser  = rq_fin[rptr];

endmodule

>>> rtl/core/grain_sample_player_unit.sv
// Top level of the grain sample player: linear-interpolating sample playback.
// Depends on gsp_pkg, gsp_seq, gsp_sram, gsp_interp.
//
//  channel  dir  beat fields (low bit first)
//  s_*      in   tuser: op[1:0]; tdata: load_address[15:0], load_value[31:16]
//  m_*      out  tdata: audio_out[15:0]; tuser: grain_finished[0]
//  cfg_*    in   write enable, register index, write data (no read-back)
//
// Load and start beats do not hold the input; a tick holds off the input while its two
// neighboring entries come one after the other through the memory read port.
// A tick result passes the issue, stage 2 and stage 3 registers and waits in a 4-entry queue.
// rst is synchronous; the sample memory is not cleared and holds garbage until loaded.
// s_tready drops while a tick holds the read port and while the queue's credits run out.
module grain_sample_player_unit
  import gsp_pkg::*;
#(
  parameter int FRAC_BITS    = 8,
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // load_address, load_value
  input  logic [1:0]            s_tuser,   // op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // audio_out
  output logic                  m_tuser    // grain_finished
);

  localparam int AW = $clog2(SAMPLE_DEPTH);

  logic                wr_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [SAMPLE_W-1:0] wr_data, rdata;
  logic                out_pop;
  tick_info_t          issue;

  assign out_pop = m_tvalid & m_tready;

  gsp_seq #(
    .FRAC_BITS    (FRAC_BITS),
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .AW           (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .out_pop   (out_pop),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .issue     (issue)
  );

  gsp_sram #(
    .DEPTH (SAMPLE_DEPTH),
    .AW    (AW),
    .DW    (SAMPLE_W)
  ) u_sram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  gsp_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .rdata    (rdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

>>> rtl/core/gsp_checker.sv
// Port-level checks for grain_sample_player_unit, attached by bind.
// Depends on gsp_pkg and grain_sample_player_unit_macros.svh.
`include "grain_sample_player_unit_macros.svh"

module gsp_checker
  import gsp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  logic       tick_beat, out_beat, out_stall;
  logic [3:0] pending;

  assign tick_beat = s_tvalid && s_tready && (s_tuser == OP_TICK);
  assign out_beat  = m_tvalid && m_tready;
  assign out_stall = m_tvalid && !m_tready;

  // ticks seen on the input not yet answered on the output
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(tick_beat) - 4'(out_beat);
    end
  end

  `GSP_ASSERT_NOW(a_no_spurious_result, m_tvalid, pending != 4'd0, "result without a tick")
  `GSP_ASSERT_NEXT(a_tick_holds_port, tick_beat, !s_tready, "beat taken during second read")
  `GSP_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable({m_tuser, m_tdata}), "beat changed")
  `GSP_ASSERT_ALWAYS_NEXT(a_reset_empty, rst, !m_tvalid && s_tready, "not empty after reset")

endmodule

bind grain_sample_player_unit gsp_checker u_gsp_checker (.*);
